// ===== design/assert_macros.svh =====
// Assertion macros shared by the allocator modules.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)

`endif

// ===== design/ffra_pkg.sv =====
// Shared types and constants for the first-fit region allocator.
// No dependencies.
package ffra_pkg;

    localparam int SLOTS_DEF = 512;
    localparam int IDS_DEF   = 32;

    localparam int OP_W     = 1;
    localparam int REQ_W    = 10;
    localparam int ID_W     = 5;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 9;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_IDS_OUT = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    clr_step;
        logic    capture;
        logic    scan_start;
        logic    scan_step;
        logic    mark_start;
        logic    mark_step;
        logic    tbl_rd;
        logic    free_start;
        logic    free_step;
        logic    emit;
        status_t status;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic ids_out;
        logic size_bad;
        logic id_bad;
        logic found;
        logic scan_fail;
        logic span_done;
    } sts_t;

endpackage

// ===== design/first_fit_region_allocator_core.sv =====
// Top level of the first-fit region allocator.
// Depends on ffra_pkg, ffra_ctrl, ffra_dp (and through it ffra_ram).
//
//  Channel   Handshake             Beat fields
//  --------  --------------------  -----------------------------------------
//  command   start, busy (in)      operation, request_size, region_id
//  result    done strobe (out)     status, granted_id, first_slot, last_slot
//
// Cycles: a command beat is taken at a rising edge with start high and busy low.
//   An error (ids exhausted, bad size, unknown id) shows its result the next cycle.
//   Allocate scans the slot map up to the last slot of the granted run, through the
//   registered read port of the slot map RAM, then marks each slot of the run.
//   A failed scan covers all SLOTS slots. Free reads the region table, then clears its slots.
// Reset: after rst_n the block walks the slot map, clearing one slot a cycle, with busy
//   high until every slot is clear; only then is the first command beat taken.
// Stalls: the receiver cannot stall; done is high for exactly one cycle per beat.
module first_fit_region_allocator_core #(
    parameter int SLOTS = ffra_pkg::SLOTS_DEF,
    parameter int IDS   = ffra_pkg::IDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic [ffra_pkg::OP_W-1:0]        operation,
    input  logic [ffra_pkg::REQ_W-1:0]       request_size,
    input  logic [ffra_pkg::ID_W-1:0]        region_id,
    // result channel
    output logic                             done,
    output logic [ffra_pkg::STATUS_W-1:0]    status,
    output logic [ffra_pkg::ID_W-1:0]        granted_id,
    output logic [ffra_pkg::SLOT_W-1:0]      first_slot,
    output logic [ffra_pkg::SLOT_W-1:0]      last_slot
);

    // Commands from the sequencer, flags back from the datapath.
    ffra_pkg::cmd_t cmd;
    ffra_pkg::sts_t sts;

    // Sequencer: clear pass after reset, then decode each command beat,
    // drive the scan, advance the mark or free sweep and fire the result.
    ffra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    // Datapath: slot map and region table RAMs, live bits, id counter,
    // run counter and result registers that hold the last beat.
    ffra_dp #(
        .SLOTS (SLOTS),
        .IDS   (IDS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .request_size (request_size),
        .region_id    (region_id),
        .sts          (sts),
        .done         (done),
        .status       (status),
        .granted_id   (granted_id),
        .first_slot   (first_slot),
        .last_slot    (last_slot)
    );

endmodule

// ===== design/ffra_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ffra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ffra_ctrl.sv =====
// Allocator controller: sequences clear, scan, mark and free phases.
// Depends on ffra_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffra_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ffra_pkg::OP_W-1:0]    operation,
    input  ffra_pkg::sts_t               sts,
    output ffra_pkg::cmd_t               cmd,
    output logic                         busy
);

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_SCAN     = 6'b000100,
        S_MARK     = 6'b001000,
        S_FREE_LD  = 6'b010000,
        S_FREE_CLR = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ffra_pkg::ST_OK;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (operation == ffra_pkg::OP_ALLOC)
                    begin
                        if (sts.ids_out)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = ffra_pkg::ST_IDS_OUT;
                        end
                        else if (sts.size_bad)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = ffra_pkg::ST_NO_ROOM;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (sts.id_bad)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = ffra_pkg::ST_UNKNOWN;
                        end
                        else
                        begin
                            cmd.tbl_rd = 1'b1;
                            state_next = S_FREE_LD;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.found)
                begin
                    cmd.mark_start = 1'b1;
                    state_next     = S_MARK;
                end
                else if (sts.scan_fail)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = ffra_pkg::ST_NO_ROOM;
                    state_next = S_IDLE;
                end
            end
            S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (sts.span_done)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FREE_LD:
            begin
                cmd.free_start = 1'b1;
                state_next     = S_FREE_CLR;
            end
            S_FREE_CLR:
            begin
                cmd.free_step = 1'b1;
                if (sts.span_done)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `ASSERT_PROP(a_emit_to_idle, clk, rst_n, cmd.emit |=> state_reg == S_IDLE, "result beat not followed by idle")
    `ASSERT_NEVER(a_scan_no_early_emit, clk, rst_n, $past(cmd.scan_start) && cmd.emit, "scan ended before any slot was read")

endmodule

// ===== design/ffra_dp.sv =====
// Allocator datapath: slot map RAM, region table RAM, live bits, id counter,
// scan/mark pointers and result registers. Depends on ffra_pkg, ffra_ram,
// assert_macros.svh.
`include "assert_macros.svh"

module ffra_dp #(
    parameter int SLOTS = ffra_pkg::SLOTS_DEF,
    parameter int IDS   = ffra_pkg::IDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ffra_pkg::cmd_t                   cmd,
    input  logic [ffra_pkg::REQ_W-1:0]       request_size,
    input  logic [ffra_pkg::ID_W-1:0]        region_id,
    output ffra_pkg::sts_t                   sts,
    output logic                             done,
    output logic [ffra_pkg::STATUS_W-1:0]    status,
    output logic [ffra_pkg::ID_W-1:0]        granted_id,
    output logic [ffra_pkg::SLOT_W-1:0]      first_slot,
    output logic [ffra_pkg::SLOT_W-1:0]      last_slot
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = $clog2(IDS);
    localparam int NW = $clog2(IDS + 1);

    // control state
    logic [SW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic           pend_reg, pend_next;
    logic [CW-1:0]  run_reg, run_next;
    logic [IDS-1:0] live_reg, live_next;
    logic [NW-1:0]  next_id_reg, next_id_next;
    logic           done_reg;

    // payload
    logic [CW-1:0]     size_reg;
    logic [IW-1:0]     id_reg;
    logic [SW-1:0]     chk_reg;
    logic [SW-1:0]     end_reg;
    logic [SW-1:0]     first_reg;
    logic [SW-1:0]     last_reg;
    ffra_pkg::status_t status_reg;
    logic [ffra_pkg::ID_W-1:0]   gid_reg;
    logic [ffra_pkg::SLOT_W-1:0] fs_reg;
    logic [ffra_pkg::SLOT_W-1:0] ls_reg;

    logic          slot_wr_en;
    logic [0:0]    slot_wr_data;
    logic          slot_rd_en;
    logic [0:0]    slot_rd_data;
    logic [2*SW-1:0] tbl_wr_data;
    logic [2*SW-1:0] tbl_rd_data;

    logic          rd_in_range;
    logic [CW-1:0] run_eval;
    logic [CW-1:0] first_calc;
    logic [SW-1:0] found_first;
    logic [IW-1:0] id_in;
    logic [IW-1:0] new_id;
    logic          id_range;
    logic          found;

    assign rd_in_range = (32'(rd_ptr_reg) < SLOTS);
    assign run_eval    = slot_rd_data[0] ? '0 : run_reg + CW'(1);
    assign found       = pend_reg && (run_eval == size_reg);
    assign first_calc  = CW'(chk_reg) + CW'(1) - size_reg;
    assign found_first = first_calc[SW-1:0];
    assign id_in       = IW'(region_id);
    assign new_id      = next_id_reg[IW-1:0];
    assign id_range    = (region_id != '0) && (32'(region_id) < IDS);

    assign sts.clr_done  = (wr_ptr_reg == SW'(SLOTS - 1));
    assign sts.ids_out   = (32'(next_id_reg) >= IDS);
    assign sts.size_bad  = (request_size == '0) || (32'(request_size) > SLOTS);
    assign sts.id_bad    = !id_range || !live_reg[id_in];
    assign sts.found     = found;
    assign sts.scan_fail = pend_reg && !found && (chk_reg == SW'(SLOTS - 1));
    assign sts.span_done = (wr_ptr_reg == end_reg);

    // slot map: one bit per slot, set while owned
    assign slot_wr_en   = cmd.clr_step || cmd.mark_step || cmd.free_step;
    assign slot_wr_data = cmd.mark_step;
    assign slot_rd_en   = cmd.scan_step && rd_in_range;

    ffra_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (rd_ptr_reg[SW-1:0]),
        .rd_data (slot_rd_data)
    );

    // region table: {first, last} per id
    assign tbl_wr_data = {found_first, chk_reg};

    ffra_ram #(
        .WIDTH (2 * SW),
        .DEPTH (IDS)
    ) u_tbl_ram (
        .clk     (clk),
        .wr_en   (cmd.mark_start),
        .wr_addr (new_id),
        .wr_data (tbl_wr_data),
        .rd_en   (cmd.tbl_rd),
        .rd_addr (id_in),
        .rd_data (tbl_rd_data)
    );

    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        pend_next    = pend_reg;
        run_next     = run_reg;
        live_next    = live_reg;
        next_id_next = next_id_reg;

        if (slot_wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + SW'(1);
        end
        if (cmd.mark_start)
        begin
            wr_ptr_next          = found_first;
            live_next[new_id]    = 1'b1;
            next_id_next         = next_id_reg + NW'(1);
        end
        if (cmd.free_start)
        begin
            wr_ptr_next       = tbl_rd_data[2*SW-1:SW];
            live_next[id_reg] = 1'b0;
        end

        if (cmd.scan_start)
        begin
            rd_ptr_next = '0;
            pend_next   = 1'b0;
            run_next    = '0;
        end
        else if (cmd.scan_step)
        begin
            pend_next = rd_in_range;
            if (rd_in_range)
            begin
                rd_ptr_next = rd_ptr_reg + CW'(1);
            end
            if (pend_reg)
            begin
                run_next = run_eval;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            pend_reg    <= 1'b0;
            run_reg     <= '0;
            live_reg    <= '0;
            next_id_reg <= NW'(1);
            done_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            pend_reg    <= pend_next;
            run_reg     <= run_next;
            live_reg    <= live_next;
            next_id_reg <= next_id_next;
            done_reg    <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            size_reg <= CW'(request_size);
            id_reg   <= id_in;
        end
        if (cmd.scan_step)
        begin
            chk_reg <= rd_ptr_reg[SW-1:0];
        end
        if (cmd.mark_start)
        begin
            id_reg    <= new_id;
            first_reg <= found_first;
            last_reg  <= chk_reg;
            end_reg   <= chk_reg;
        end
        if (cmd.free_start)
        begin
            first_reg <= tbl_rd_data[2*SW-1:SW];
            last_reg  <= tbl_rd_data[SW-1:0];
            end_reg   <= tbl_rd_data[SW-1:0];
        end
        if (cmd.emit)
        begin
            status_reg <= cmd.status;
            if (cmd.status == ffra_pkg::ST_OK)
            begin
                gid_reg <= ffra_pkg::ID_W'(id_reg);
                fs_reg  <= ffra_pkg::SLOT_W'(first_reg);
                ls_reg  <= ffra_pkg::SLOT_W'(last_reg);
            end
            else
            begin
                gid_reg <= '0;
                fs_reg  <= '0;
                ls_reg  <= '0;
            end
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign granted_id = gid_reg;
    assign first_slot = fs_reg;
    assign last_slot  = ls_reg;

    `ASSERT_PROP(a_span_bound, clk, rst_n, (cmd.mark_step || cmd.free_step) |-> wr_ptr_reg <= end_reg, "slot write pointer passed the end of the span")
    `ASSERT_NEVER(a_no_id_when_out, clk, rst_n, cmd.mark_start && sts.ids_out, "region marked with ids exhausted")
    `ASSERT_PROP(a_ok_bounds, clk, rst_n, (cmd.emit && cmd.status == ffra_pkg::ST_OK) |-> first_reg <= last_reg, "granted region has first slot after last slot")

endmodule

// ===== test/region_grant_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the first-fit region allocator: mirrors the slot map and id table.
// Depends on ffra_pkg; instantiated by tb_top beside the allocator core.
module region_grant_checker
    import ffra_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [OP_W-1:0]     operation,
    input  logic [REQ_W-1:0]    request_size,
    input  logic [ID_W-1:0]     region_id,
    input  logic                done,
    input  logic [STATUS_W-1:0] status,
    input  logic [ID_W-1:0]     granted_id,
    input  logic [SLOT_W-1:0]   first_slot,
    input  logic [SLOT_W-1:0]   last_slot,
    output int                  failures,
    output int                  outstanding
);

    typedef struct packed {
        status_t             status;
        logic [ID_W-1:0]     granted_id;
        logic [SLOT_W-1:0]   first_slot;
        logic [SLOT_W-1:0]   last_slot;
    } grant_t;

    logic [ID_W-1:0]   slot_map [SLOTS_DEF];
    logic [SLOT_W-1:0] span_lo  [IDS_DEF];
    logic [SLOT_W-1:0] span_hi  [IDS_DEF];
    logic              id_live  [IDS_DEF];
    logic [ID_W:0]     id_cursor;

    grant_t grants_due [$];
    int     mismatch_count = 0;

    assign failures = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Apply one command beat to the mirrored map and return the grant it yields.
    function automatic grant_t grant_for(op_t op, logic [REQ_W-1:0] size,
                                         logic [ID_W-1:0] id);
        grant_t g;
        int     run;
        int     base;
        g.status     = ST_OK;
        g.granted_id = '0;
        g.first_slot = '0;
        g.last_slot  = '0;
        if (op == OP_ALLOC)
        begin
            if (id_cursor >= IDS_DEF)
            begin
                g.status = ST_IDS_OUT;
            end
            else if (size == 0 || size > SLOTS_DEF)
            begin
                g.status = ST_NO_ROOM;
            end
            else
            begin
                run  = 0;
                base = -1;
                for (int i = 0; i < SLOTS_DEF && base < 0; i++)
                begin
                    run = (slot_map[i] != '0) ? 0 : run + 1;
                    if (run == int'(size))
                        base = i + 1 - int'(size);
                end
                if (base < 0)
                begin
                    g.status = ST_NO_ROOM;
                end
                else
                begin
                    for (int k = base; k < base + int'(size); k++)
                        slot_map[k] = id_cursor[ID_W-1:0];
                    span_lo[id_cursor] = SLOT_W'(base);
                    span_hi[id_cursor] = SLOT_W'(base + int'(size) - 1);
                    id_live[id_cursor] = 1'b1;
                    g.granted_id = id_cursor[ID_W-1:0];
                    g.first_slot = SLOT_W'(base);
                    g.last_slot  = SLOT_W'(base + int'(size) - 1);
                    id_cursor++;
                end
            end
        end
        else
        begin
            if (id == '0 || !id_live[id])
            begin
                g.status = ST_UNKNOWN;
            end
            else
            begin
                for (int k = int'(span_lo[id]); k <= int'(span_hi[id]); k++)
                    slot_map[k] = '0;
                id_live[id]  = 1'b0;
                g.granted_id = id;
                g.first_slot = span_lo[id];
                g.last_slot  = span_hi[id];
            end
        end
        return g;
    endfunction

    always @(posedge clk)
    begin
        grant_t want;
        if (!rst_n)
        begin
            foreach (slot_map[i]) slot_map[i] = '0;
            foreach (id_live[i])
            begin
                id_live[i] = 1'b0;
                span_lo[i] = '0;
                span_hi[i] = '0;
            end
            id_cursor = (ID_W + 1)'(1);
            grants_due.delete();
        end
        else
        begin
            // retire the result beat first: it belongs to an older command
            if (done === 1'b1)
            begin
                if (grants_due.size() == 0)
                begin
                    report_mismatch($sformatf("result beat with none pending (status %0d)",
                                              status));
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  status, want.status));
                    if (granted_id !== want.granted_id)
                        report_mismatch($sformatf("granted_id got %0d want %0d",
                                                  granted_id, want.granted_id));
                    if (first_slot !== want.first_slot)
                        report_mismatch($sformatf("first_slot got %0d want %0d",
                                                  first_slot, want.first_slot));
                    if (last_slot !== want.last_slot)
                        report_mismatch($sformatf("last_slot got %0d want %0d",
                                                  last_slot, want.last_slot));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                grants_due.push_back(grant_for(op_t'(operation), request_size, region_id));
        end
        outstanding <= grants_due.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for first_fit_region_allocator_core: clock, reset, command beats, verdict.
// Depends on ffra_pkg, the allocator RTL and region_grant_checker.
module tb_top;
    import ffra_pkg::*;

    // Slowest legal run: ~1025 beats, each a full scan plus full mark,
    // the reset clearing pass and sender gaps; take it several times over.
    localparam int CYCLE_LIMIT  = 4_000_000;
    // Longest single command: scan all slots, then mark all slots.
    localparam int DRAIN_CYCLES = 1100;
    localparam int RANDOM_BEATS = 1000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic [OP_W-1:0]    operation    = OP_ALLOC;
    logic [REQ_W-1:0]   request_size = '0;
    logic [ID_W-1:0]    region_id    = '0;
    logic               busy;
    logic               done;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]    granted_id;
    logic [SLOT_W-1:0]  first_slot;
    logic [SLOT_W-1:0]  last_slot;

    int fail_total;
    int in_flight;
    int idle_pct    = 0;   // chance in a hundred that the sender idles a cycle
    int allocs_sent = 0;   // upper bound on ids handed out so far
    int cycle_count = 0;

    always #2 clk = ~clk;

    first_fit_region_allocator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .request_size (request_size),
        .region_id    (region_id),
        .done         (done),
        .status       (status),
        .granted_id   (granted_id),
        .first_slot   (first_slot),
        .last_slot    (last_slot)
    );

    region_grant_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .request_size (request_size),
        .region_id    (region_id),
        .done         (done),
        .status       (status),
        .granted_id   (granted_id),
        .first_slot   (first_slot),
        .last_slot    (last_slot),
        .failures     (fail_total),
        .outstanding  (in_flight)
    );

    // Send one command beat. Idle first at the phase's rate, then hold start high
    // until an edge sees busy low. Leave start high afterwards: the next beat either
    // reuses it in the same step or drops it when it idles, so start never gets
    // two assignments in one step.
    task automatic send_beat(input op_t op, input logic [REQ_W-1:0] size,
                             input logic [ID_W-1:0] id);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= op;
        request_size <= size;
        region_id    <= id;
        if (op == OP_ALLOC)
            allocs_sent++;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // One random beat. Allocate sizes lean small so regions pile up, with a share of
    // large and out-of-range sizes to force full scans and no-room results. Most frees
    // aim at ids that may have been issued; the rest hit any id, unknown ones included.
    task automatic random_beat();
        int pick;
        int sel;
        int top_id;
        logic [REQ_W-1:0] size;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            sel = $urandom_range(99);
            if (sel < 35)
                size = REQ_W'($urandom_range(16, 1));
            else if (sel < 70)
                size = REQ_W'($urandom_range(300, 17));
            else if (sel < 90)
                size = REQ_W'($urandom_range(512, 301));
            else
                size = REQ_W'($urandom_range(1023, 0));
            send_beat(OP_ALLOC, size, ID_W'($urandom_range(31, 0)));
        end
        else if (pick < 80)
        begin
            top_id = (allocs_sent > 31) ? 31 : ((allocs_sent < 1) ? 1 : allocs_sent);
            send_beat(OP_FREE, REQ_W'($urandom_range(1023, 0)),
                      ID_W'($urandom_range(top_id, 1)));
        end
        else
        begin
            send_beat(OP_FREE, REQ_W'($urandom_range(1023, 0)),
                      ID_W'($urandom_range(31, 0)));
        end
    endtask

    // Watchdog: end the run if the block hangs or results go missing.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("first_fit_region_allocator_core verification failed");
        $finish;
    end

    initial
    begin
        // hold reset at start; the block then clears its slot map with busy high
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: unknown ids, bad sizes, a full-map region, double free,
        // hole reuse by first fit, and a full map that refuses one slot.
        send_beat(OP_FREE,  10'd0,    5'd0);     // id zero is never live
        send_beat(OP_FREE,  10'd0,    5'd31);    // id not yet issued
        send_beat(OP_ALLOC, 10'd0,    5'd0);     // size zero, refused as no room
        send_beat(OP_ALLOC, 10'd1023, 5'd31);    // size far above the map
        send_beat(OP_ALLOC, 10'd513,  5'd0);     // size one above the map
        send_beat(OP_ALLOC, 10'd512,  5'd0);     // whole map, id 1
        send_beat(OP_ALLOC, 10'd1,    5'd0);     // map full, no room
        send_beat(OP_FREE,  10'd0,    5'd1);     // release the whole map
        send_beat(OP_FREE,  10'd0,    5'd1);     // double free
        send_beat(OP_ALLOC, 10'd1,    5'd0);     // id 2 at slot 0
        send_beat(OP_ALLOC, 10'd3,    5'd0);     // id 3 at 1..3
        send_beat(OP_ALLOC, 10'd2,    5'd0);     // id 4 at 4..5
        send_beat(OP_FREE,  10'd0,    5'd3);     // open a three-slot hole
        send_beat(OP_ALLOC, 10'd4,    5'd0);     // too big for the hole, goes past it
        send_beat(OP_ALLOC, 10'd3,    5'd0);     // fills the hole exactly
        send_beat(OP_ALLOC, 10'd502,  5'd0);     // rest of the map up to slot 511
        send_beat(OP_ALLOC, 10'd1,    5'd0);     // full again
        send_beat(OP_FREE,  10'd0,    5'd7);     // release the top run
        send_beat(OP_FREE,  10'd0,    5'd2);
        send_beat(OP_FREE,  10'd0,    5'd5);
        send_beat(OP_FREE,  10'd1023, 5'd21);    // unknown id, alternating bits
        send_beat(OP_FREE,  10'd682,  5'd10);    // unknown id, the other pattern

        // Random: rotate sender idling through none, heavy, none, light.
        // Ids run out partway; later allocates then report ids exhausted.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            case ((n / 100) % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 54;
                2:       idle_pct = 0;
                default: idle_pct = 8;
            endcase
            random_beat();
        end
        start <= 1'b0;

        // drain: let the checker's count settle, wait out pending results, then linger
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_total == 0)
            $display("first_fit_region_allocator_core verification clean");
        else
            $display("first_fit_region_allocator_core verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/ffra_pkg.sv
design/ffra_ram.sv
design/ffra_ctrl.sv
design/ffra_dp.sv
design/first_fit_region_allocator_core.sv
test/region_grant_checker.sv
test/tb_top.sv
